FILE: rtl/esm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esm_pkg
// Shared types, constants and the min-select function for the sorted merge.
// ----------------------------------------------------------------------------
package esm_pkg;

    localparam int ESM_LIST_COUNT = 8;
    localparam int ESM_LIST_DEPTH = 8;
    localparam int DATA_W         = 32;
    localparam int ID_W           = 3;
    localparam int MAX_LISTS      = 8;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_MERGE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_FILL,
        ST_PICK
    } esm_state_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] val;
        logic [ID_W-1:0]          idx;
    } esm_node_t;

    typedef struct packed {
        logic rd_en;
        logic clear;
    } esm_ctl_t;

    // Keep the left node on a tie so the lower list wins.
    function automatic esm_node_t node_min(input esm_node_t a, input esm_node_t b);
        esm_node_t r;
        if (a.valid && (!b.valid || ($signed(a.val) <= $signed(b.val))))
            r = a;
        else
            r = b;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/esm_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esm_store
// List memory with per-list fill counts, running total and drop flag.
// ----------------------------------------------------------------------------
module esm_store
    import esm_pkg::*;
#(
    parameter int LIST_COUNT = ESM_LIST_COUNT,
    parameter int LIST_DEPTH = ESM_LIST_DEPTH,
    localparam int LIST_W    = $clog2(LIST_COUNT),
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
    localparam int SLOTS     = LIST_COUNT * LIST_DEPTH,
    localparam int ADDR_W    = $clog2(SLOTS),
    localparam int TOT_W     = $clog2(SLOTS + 1)
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                app_en,
    input  wire logic [ID_W-1:0]                     list_id,
    input  wire logic [DATA_W-1:0]                   value,
    input  wire esm_ctl_t                            ctl,
    input  wire logic [ADDR_W-1:0]                   rd_addr,
    output logic      [DATA_W-1:0]                   rdata,
    output logic      [LIST_COUNT-1:0][CNT_W-1:0]    counts,
    output logic      [TOT_W-1:0]                    total,
    output logic                                     dropped
);

    logic [DATA_W-1:0]               mem [SLOTS];
    logic [DATA_W-1:0]               rdata_reg;
    logic [LIST_COUNT-1:0][CNT_W-1:0] counts_reg;
    logic [TOT_W-1:0]                total_reg;
    logic                            dropped_reg;

    logic              in_range;
    logic [LIST_W-1:0] lid;
    logic              full;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    always_comb
    begin
        in_range = ({1'b0, list_id} < (ID_W + 1)'(LIST_COUNT));
        lid      = list_id[LIST_W-1:0];
        full     = (counts_reg[lid] >= CNT_W'(LIST_DEPTH));
        wr_en    = app_en && in_range && !full;
        wr_addr  = ADDR_W'(lid) * ADDR_W'(LIST_DEPTH) + ADDR_W'(counts_reg[lid]);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg  <= '0;
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            counts_reg  <= '0;
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (app_en && in_range)
        begin
            if (full)
            begin
                dropped_reg <= 1'b1;
            end
            else
            begin
                counts_reg[lid] <= counts_reg[lid] + 1'b1;
                total_reg       <= total_reg + 1'b1;
            end
        end
    end

    assign rdata   = rdata_reg;
    assign counts  = counts_reg;
    assign total   = total_reg;
    assign dropped = dropped_reg;

endmodule
`default_nettype wire

FILE: rtl/esm_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esm_merge
// Merge sequencer: primes list heads from memory, picks the smallest head,
// emits it and refills that head from memory.
// ----------------------------------------------------------------------------
module esm_merge
    import esm_pkg::*;
#(
    parameter int LIST_COUNT = ESM_LIST_COUNT,
    parameter int LIST_DEPTH = ESM_LIST_DEPTH,
    localparam int LIST_W    = $clog2(LIST_COUNT),
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
    localparam int SLOTS     = LIST_COUNT * LIST_DEPTH,
    localparam int ADDR_W    = $clog2(SLOTS),
    localparam int TOT_W     = $clog2(SLOTS + 1)
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             go,
    input  wire logic [LIST_COUNT-1:0][CNT_W-1:0] counts,
    input  wire logic [TOT_W-1:0]                 total,
    input  wire logic                             dropped,
    input  wire logic [DATA_W-1:0]                rdata,
    output esm_ctl_t                              ctl,
    output logic      [ADDR_W-1:0]                rd_addr,
    output logic                                  busy,
    output logic                                  valid,
    output logic signed [DATA_W-1:0]              merged_value,
    output logic                                  last,
    output logic                                  empty_res,
    output logic                                  overflow
);

    esm_state_t state_reg, state_next;

    logic [LIST_W-1:0]  prime_cnt_reg;
    logic [CNT_W-1:0]   ptr_reg [LIST_COUNT];
    logic [DATA_W-1:0]  head_reg [LIST_COUNT];
    logic               fill_pend_reg;
    logic [LIST_W-1:0]  fill_list_reg;
    logic [TOT_W-1:0]   remain_reg;

    logic                     valid_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     last_reg;
    logic                     empty_reg;
    logic                     ovf_reg;

    esm_node_t leaf [MAX_LISTS];
    esm_node_t lvl1 [MAX_LISTS / 2];
    esm_node_t lvl2 [MAX_LISTS / 4];
    esm_node_t root;

    logic [LIST_W-1:0] win_list;
    logic [CNT_W-1:0]  ptr_inc;
    logic [LIST_W-1:0] rd_list;
    logic [CNT_W-1:0]  rd_idx;
    logic              rd_en;
    logic              clear;
    logic              pick;
    logic              empty_go;
    logic              final_pick;

    for (genvar g = 0; g < MAX_LISTS; g++)
    begin : g_leaf
        if (g < LIST_COUNT)
        begin : g_used
            assign leaf[g] = '{valid: (ptr_reg[g] < counts[g]),
                               val:   head_reg[g],
                               idx:   ID_W'(g)};
        end
        else
        begin : g_pad
            assign leaf[g] = '{valid: 1'b0, val: '0, idx: ID_W'(g)};
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_LISTS / 2; j++)
        begin
            lvl1[j] = node_min(leaf[2 * j], leaf[2 * j + 1]);
        end
        for (int k = 0; k < MAX_LISTS / 4; k++)
        begin
            lvl2[k] = node_min(lvl1[2 * k], lvl1[2 * k + 1]);
        end
        root     = node_min(lvl2[0], lvl2[1]);
        win_list = root.idx[LIST_W-1:0];
        ptr_inc  = ptr_reg[win_list] + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go && (total != '0))
                    state_next = ST_PRIME;
            end
            ST_PRIME:
            begin
                if (prime_cnt_reg == LIST_W'(LIST_COUNT - 1))
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (remain_reg == TOT_W'(1))
                    state_next = ST_IDLE;
                else
                    state_next = ST_FILL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en      = 1'b0;
        rd_list    = '0;
        rd_idx     = '0;
        clear      = 1'b0;
        pick       = 1'b0;
        empty_go   = 1'b0;
        final_pick = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go && (total == '0))
                begin
                    empty_go = 1'b1;
                    clear    = 1'b1;
                end
            end
            ST_PRIME:
            begin
                rd_en   = 1'b1;
                rd_list = prime_cnt_reg;
            end
            ST_FILL:
            begin
                rd_en = 1'b0;
            end
            ST_PICK:
            begin
                pick       = 1'b1;
                final_pick = (remain_reg == TOT_W'(1));
                clear      = final_pick;
                rd_list    = win_list;
                rd_idx     = ptr_inc;
                rd_en      = (ptr_inc < counts[win_list]);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
        rd_addr   = ADDR_W'(rd_list) * ADDR_W'(LIST_DEPTH) + ADDR_W'(rd_idx);
        ctl.rd_en = rd_en;
        ctl.clear = clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prime_cnt_reg <= '0;
            fill_pend_reg <= 1'b0;
            fill_list_reg <= '0;
            remain_reg    <= '0;
            valid_reg     <= 1'b0;
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                ptr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_pend_reg <= rd_en;
            fill_list_reg <= rd_list;
            valid_reg     <= pick || empty_go;
            if (state_reg == ST_PRIME)
                prime_cnt_reg <= prime_cnt_reg + 1'b1;
            else
                prime_cnt_reg <= '0;
            if ((state_reg == ST_IDLE) && go)
                remain_reg <= total;
            else if (pick)
                remain_reg <= remain_reg - 1'b1;
            if (final_pick)
            begin
                for (int i = 0; i < LIST_COUNT; i++)
                begin
                    ptr_reg[i] <= '0;
                end
            end
            else if (pick)
            begin
                ptr_reg[win_list] <= ptr_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_pend_reg)
        begin
            head_reg[fill_list_reg] <= rdata;
        end
        if (pick || empty_go)
        begin
            value_reg <= pick ? root.val : '0;
            last_reg  <= empty_go || final_pick;
            empty_reg <= empty_go;
            ovf_reg   <= dropped;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign valid        = valid_reg;
    assign merged_value = value_reg;
    assign last         = last_reg;
    assign empty_res    = empty_reg;
    assign overflow     = ovf_reg;

endmodule
`default_nettype wire

FILE: rtl/eight_way_sorted_merge_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Append: busy stays low, so a new append beat may follow at once.
// Merge of N stored values: the sequencer primes every list head from memory, then
// alternates fill and pick states; each pick gives one of the N results and refills its head.
// Busy stays high until the final result; an empty merge gives its result next cycle.
// The receiver cannot stall; each result shows for exactly one cycle on valid.
// Reset (async, active low) clears counts, drop flag and sequencer; memory is not cleared.
// ----------------------------------------------------------------------------
// eight_way_sorted_merge_top
// Eight sorted lists loaded by append beats, merged into one ascending stream.
// ----------------------------------------------------------------------------
module eight_way_sorted_merge_top
    import esm_pkg::*;
#(
    parameter int LIST_COUNT = ESM_LIST_COUNT,
    parameter int LIST_DEPTH = ESM_LIST_DEPTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     op,
    input  wire logic [ID_W-1:0]          list_id,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          valid,
    output logic signed [DATA_W-1:0]      merged_value,
    output logic                          last,
    output logic                          empty_res,
    output logic                          overflow
);

    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int SLOTS  = LIST_COUNT * LIST_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int TOT_W  = $clog2(SLOTS + 1);

    logic                             accept;
    logic                             app_en;
    logic                             go;
    esm_ctl_t                         ctl;
    logic [ADDR_W-1:0]                rd_addr;
    logic [DATA_W-1:0]                rdata;
    logic [LIST_COUNT-1:0][CNT_W-1:0] counts;
    logic [TOT_W-1:0]                 total;
    logic                             dropped;

    assign accept = start && !busy;
    assign app_en = accept && (op == OP_APPEND);
    assign go     = accept && (op == OP_MERGE);

    esm_store #(
        .LIST_COUNT (LIST_COUNT),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .app_en  (app_en),
        .list_id (list_id),
        .value   (value),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .rdata   (rdata),
        .counts  (counts),
        .total   (total),
        .dropped (dropped)
    );

    esm_merge #(
        .LIST_COUNT (LIST_COUNT),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .counts       (counts),
        .total        (total),
        .dropped      (dropped),
        .rdata        (rdata),
        .ctl          (ctl),
        .rd_addr      (rd_addr),
        .busy         (busy),
        .valid        (valid),
        .merged_value (merged_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && empty_res) |-> last)
        else $error("empty result without last");

    a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (valid && last && !empty_res))
        else $error("merge ended without final result");

    a_merge_progresses: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> (valid || busy))
        else $error("merge beat neither answered nor started");

    a_store_quiet_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !app_en)
        else $error("append while merging");
`endif

endmodule
`default_nettype wire
